// ===== design/c65_pkg.sv =====
package c65_pkg;

    // Memory geometry
    localparam int unsigned MEM_DEPTH  = 65536;
    localparam int unsigned MEM_AW     = $clog2(MEM_DEPTH);
    localparam int unsigned STACK_BASE = 256;

    localparam logic [15:0] STACK_BASE_W = 16'(STACK_BASE);
    localparam logic [15:0] VEC_RESET_LO = 16'hFFFC;
    localparam logic [15:0] VEC_RESET_HI = 16'hFFFD;

    // Restart values
    localparam logic [15:0] START_PC_RST = 16'hC000;
    localparam logic [7:0]  SP_RST       = 8'hFD;
    localparam logic [7:0]  P_RST        = 8'h34;

    // Status bits
    localparam int unsigned FL_C = 0;
    localparam int unsigned FL_Z = 1;
    localparam int unsigned FL_I = 2;
    localparam int unsigned FL_D = 3;
    localparam int unsigned FL_B = 4;
    localparam int unsigned FL_R = 5;
    localparam int unsigned FL_V = 6;
    localparam int unsigned FL_N = 7;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_VEC  = 1'b1;

    // Request commands
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_EXEC    = 2'd3;

    // Opcodes with their own handling
    localparam logic [7:0] OPC_BRK = 8'h00;
    localparam logic [7:0] OPC_PHP = 8'h08;
    localparam logic [7:0] OPC_ASL = 8'h0A;
    localparam logic [7:0] OPC_CLC = 8'h18;
    localparam logic [7:0] OPC_JSR = 8'h20;
    localparam logic [7:0] OPC_PLP = 8'h28;
    localparam logic [7:0] OPC_ROL = 8'h2A;
    localparam logic [7:0] OPC_SEC = 8'h38;
    localparam logic [7:0] OPC_RTI = 8'h40;
    localparam logic [7:0] OPC_PHA = 8'h48;
    localparam logic [7:0] OPC_LSR = 8'h4A;
    localparam logic [7:0] OPC_JMP = 8'h4C;
    localparam logic [7:0] OPC_CLI = 8'h58;
    localparam logic [7:0] OPC_RTS = 8'h60;
    localparam logic [7:0] OPC_PLA = 8'h68;
    localparam logic [7:0] OPC_ROR = 8'h6A;
    localparam logic [7:0] OPC_JMI = 8'h6C;
    localparam logic [7:0] OPC_SEI = 8'h78;
    localparam logic [7:0] OPC_DEY = 8'h88;
    localparam logic [7:0] OPC_SIM = 8'h89;
    localparam logic [7:0] OPC_TXA = 8'h8A;
    localparam logic [7:0] OPC_SHA = 8'h93;
    localparam logic [7:0] OPC_TYA = 8'h98;
    localparam logic [7:0] OPC_TXS = 8'h9A;
    localparam logic [7:0] OPC_TAS = 8'h9B;
    localparam logic [7:0] OPC_SHY = 8'h9C;
    localparam logic [7:0] OPC_SHX = 8'h9E;
    localparam logic [7:0] OPC_SHB = 8'h9F;
    localparam logic [7:0] OPC_LDI = 8'hA2;
    localparam logic [7:0] OPC_TAY = 8'hA8;
    localparam logic [7:0] OPC_TAX = 8'hAA;
    localparam logic [7:0] OPC_CLV = 8'hB8;
    localparam logic [7:0] OPC_TSX = 8'hBA;
    localparam logic [7:0] OPC_LAS = 8'hBB;
    localparam logic [7:0] OPC_INY = 8'hC8;
    localparam logic [7:0] OPC_DEX = 8'hCA;
    localparam logic [7:0] OPC_CLD = 8'hD8;
    localparam logic [7:0] OPC_INX = 8'hE8;
    localparam logic [7:0] OPC_SBI = 8'hEB;
    localparam logic [7:0] OPC_SED = 8'hF8;

    typedef enum logic [4:0] {
        S_IDLE, S_MEMRD, S_VEC1, S_VEC2, S_OP, S_B1, S_B2, S_P1, S_P2,
        S_EXEC, S_DATA, S_PULL1, S_PULL2, S_PULL3, S_JSR2, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        M_IMP, M_IMM, M_ZPG, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_INX, M_INY, M_REL
    } mode_t;

    typedef enum logic [3:0] {
        K_UNIMPL, K_IMPLIED, K_PUSH, K_PULL, K_NOADDR, K_READ, K_STORE, K_RMW,
        K_BRANCH, K_JSR, K_JMP, K_JMPI
    } kind_t;

    typedef enum logic [4:0] {
        A_NONE, A_ORA, A_AND, A_EOR, A_ADC, A_LDA, A_CMP, A_SBC, A_BIT, A_LDY,
        A_CPY, A_CPX, A_LDX, A_LAX, A_ASL, A_ROL, A_LSR, A_ROR, A_DEC, A_INC,
        A_SLO, A_RLA, A_SRE, A_RRA, A_DCP, A_ISB, A_STA, A_STX, A_STY, A_SAX
    } alu_t;

    typedef struct packed {
        mode_t mode;
        kind_t kind;
        alu_t  alu;
    } dec_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } cmd_t;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic [7:0]  p;
        logic [7:0]  mem_data;
        logic        unimpl;
    } res_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    // Column-based addressing mode of the regular groups
    function automatic mode_t std_mode(logic [2:0] bbb);
        mode_t m;
        case (bbb)
            3'd0:    m = M_INX;
            3'd1:    m = M_ZPG;
            3'd2:    m = M_IMM;
            3'd3:    m = M_ABS;
            3'd4:    m = M_INY;
            3'd5:    m = M_ZPX;
            3'd6:    m = M_ABY;
            default: m = M_ABX;
        endcase
        return m;
    endfunction

    function automatic dec_t decode(logic [7:0] op);
        dec_t       d;
        logic [2:0] aaa;
        logic [2:0] bbb;
        logic [1:0] cc;
        logic       bad;
        aaa = op[7:5];
        bbb = op[4:2];
        cc  = op[1:0];
        d.mode = M_IMP;
        d.kind = K_IMPLIED;
        d.alu  = A_NONE;
        bad = (op == OPC_BRK) || (op == OPC_CLI) || (op == OPC_SHY) || (op == OPC_SIM)
           || (op == OPC_SHX) || (op == OPC_SHA) || (op == OPC_TAS) || (op == OPC_LAS)
           || (op == OPC_SHB)
           || (cc == 2'd2 && bbb == 3'd0 && op != OPC_LDI)
           || (cc == 2'd2 && bbb == 3'd4)
           || (cc == 2'd3 && bbb == 3'd2 && op != OPC_SBI);
        if (bad) begin
            d.kind = K_UNIMPL;
        end
        else if (cc == 2'd0) begin
            if (bbb == 3'd4) begin
                d.mode = M_REL;
                d.kind = K_BRANCH;
            end
            else if (op == OPC_JSR) begin
                d.mode = M_ABS;
                d.kind = K_JSR;
            end
            else if (op == OPC_RTI || op == OPC_RTS || op == OPC_PLP || op == OPC_PLA) begin
                d.kind = K_PULL;
            end
            else if (op == OPC_JMP) begin
                d.mode = M_ABS;
                d.kind = K_JMP;
            end
            else if (op == OPC_JMI) begin
                d.mode = M_ABS;
                d.kind = K_JMPI;
            end
            else if (op == OPC_PHP || op == OPC_PHA) begin
                d.kind = K_PUSH;
            end
            else if (bbb == 3'd2 || bbb == 3'd6) begin
                d.kind = K_IMPLIED;
            end
            else begin
                d.mode = (bbb == 3'd0) ? M_IMM : std_mode(bbb);
                d.kind = K_NOADDR;
                case (aaa)
                    3'd1:
                    begin
                        if (bbb == 3'd1 || bbb == 3'd3) begin
                            d.kind = K_READ;
                            d.alu  = A_BIT;
                        end
                    end
                    3'd4:
                    begin
                        if (bbb != 3'd0) begin
                            d.kind = K_STORE;
                            d.alu  = A_STY;
                        end
                    end
                    3'd5:
                    begin
                        d.kind = K_READ;
                        d.alu  = A_LDY;
                    end
                    3'd6:
                    begin
                        if (bbb == 3'd0 || bbb == 3'd1 || bbb == 3'd3) begin
                            d.kind = K_READ;
                            d.alu  = A_CPY;
                        end
                    end
                    3'd7:
                    begin
                        if (bbb == 3'd0 || bbb == 3'd1 || bbb == 3'd3) begin
                            d.kind = K_READ;
                            d.alu  = A_CPX;
                        end
                    end
                    default: d.kind = K_NOADDR;
                endcase
            end
        end
        else if (cc == 2'd2 && (bbb == 3'd2 || bbb == 3'd6)) begin
            d.kind = K_IMPLIED;
        end
        else begin
            d.mode = std_mode(bbb);
            if (cc == 2'd2 && bbb == 3'd0) begin
                d.mode = M_IMM;
            end
            if (cc[1] && (aaa == 3'd4 || aaa == 3'd5)) begin
                if (bbb == 3'd5) begin
                    d.mode = M_ZPY;
                end
                if (bbb == 3'd7 && (cc == 2'd3 || aaa == 3'd5)) begin
                    d.mode = M_ABY;
                end
            end
            if (cc == 2'd1 || op == OPC_SBI) begin
                d.kind = K_READ;
                case (aaa)
                    3'd0:    d.alu = A_ORA;
                    3'd1:    d.alu = A_AND;
                    3'd2:    d.alu = A_EOR;
                    3'd3:    d.alu = A_ADC;
                    3'd4:
                    begin
                        d.kind = K_STORE;
                        d.alu  = A_STA;
                    end
                    3'd5:    d.alu = A_LDA;
                    3'd6:    d.alu = A_CMP;
                    default: d.alu = A_SBC;
                endcase
            end
            else if (cc == 2'd2) begin
                d.kind = K_RMW;
                case (aaa)
                    3'd0:    d.alu = A_ASL;
                    3'd1:    d.alu = A_ROL;
                    3'd2:    d.alu = A_LSR;
                    3'd3:    d.alu = A_ROR;
                    3'd4:
                    begin
                        d.kind = K_STORE;
                        d.alu  = A_STX;
                    end
                    3'd5:
                    begin
                        d.kind = K_READ;
                        d.alu  = A_LDX;
                    end
                    3'd6:    d.alu = A_DEC;
                    default: d.alu = A_INC;
                endcase
            end
            else begin
                d.kind = K_RMW;
                case (aaa)
                    3'd0:    d.alu = A_SLO;
                    3'd1:    d.alu = A_RLA;
                    3'd2:    d.alu = A_SRE;
                    3'd3:    d.alu = A_RRA;
                    3'd4:
                    begin
                        d.kind = K_STORE;
                        d.alu  = A_SAX;
                    end
                    3'd5:
                    begin
                        d.kind = K_READ;
                        d.alu  = A_LAX;
                    end
                    3'd6:    d.alu = A_DCP;
                    default: d.alu = A_ISB;
                endcase
            end
        end
        return d;
    endfunction

endpackage

// ===== design/cpu_6502_instruction_step_core.sv =====
// 6502 core over a 64 KiB byte memory held in one single-port synchronous RAM.
// Each request writes a byte, reads a byte, restarts the core or executes one
// instruction, and returns one result with the register file after it. The
// single RAM port makes one access per cycle. A request starts in the cycle it
// is accepted and ends in the cycle that hands its result to the output
// register. Between those come its further memory accesses and the states that
// take in the data of its reads. The next request can be taken in the cycle
// after the result is handed over. A result that finds the output register
// still full holds the core in its last cycle until the register is drained.
// A finished result waits in the output register while the next request runs.
// Memory contents are undefined until written; registers reset as on restart
// with PC = 0xC000.
module cpu_6502_instruction_step_core
    import c65_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // command[1:0], mem_address[17:2], write_byte[25:18]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // pc_out[15:0], a_out[23:16], x_out[31:24],
                                            // y_out[39:32], sp_out[47:40], p_out[55:48],
                                            // mem_data[63:56], unimplemented[64]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [15:0]          cfg_wdata
);

    logic        start;
    cmd_t        req;
    logic        core_idle;
    logic        core_res_valid;
    logic        res_slot_free;
    res_t        core_res;
    mem_req_t    mem;
    logic [7:0]  mem_rdata;
    logic [15:0] start_pc_reg;
    logic        use_vec_reg;
    logic        out_valid_reg;
    res_t        out_res_reg;

    assign s_tready      = core_idle;
    assign start         = s_tvalid & s_tready;
    assign req           = '{cmd: s_tdata[1:0], addr: s_tdata[17:2], wdata: s_tdata[25:18]};
    assign res_slot_free = !out_valid_reg || m_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_pc_reg <= START_PC_RST;
            use_vec_reg  <= 1'b0;
        end
        else if (cfg_we) begin
            case (cfg_addr)
                CFG_START_PC: start_pc_reg <= cfg_wdata;
                CFG_USE_VEC:  use_vec_reg  <= cfg_wdata[0];
                default:      use_vec_reg  <= use_vec_reg;
            endcase
        end
    end

    c65_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .start_pc  (start_pc_reg),
        .use_vec   (use_vec_reg),
        .idle      (core_idle),
        .res_valid (core_res_valid),
        .res_ready (res_slot_free),
        .res       (core_res),
        .mem       (mem),
        .mem_rdata (mem_rdata)
    );

    c65_ram #(
        .ADDR_W (MEM_AW),
        .DATA_W (8)
    ) u_ram (
        .clk   (clk),
        .en    (mem.en),
        .we    (mem.we),
        .addr  (mem.addr),
        .wdata (mem.wdata),
        .rdata (mem_rdata)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (core_res_valid && res_slot_free) begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_res_valid && res_slot_free) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'h00, out_res_reg.unimpl, out_res_reg.mem_data, out_res_reg.p,
                       out_res_reg.sp, out_res_reg.y, out_res_reg.x, out_res_reg.a,
                       out_res_reg.pc};

    // The sequencer leaves idle as soon as it takes a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_tready)
        else $error("request accepted while sequencer still idle");

    // A finished result always lands in the output register
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        core_res_valid && res_slot_free |=> m_tvalid)
        else $error("finished result was dropped");

    // No memory write without a request in flight
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem.we |-> (mem.en && (!core_idle || start)))
        else $error("memory written while idle");

endmodule

// ===== design/c65_ram.sv =====
// Single-port synchronous RAM, registered read data
module c65_ram #(
    parameter int unsigned ADDR_W = 16,
    parameter int unsigned DATA_W = 8
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ===== design/c65_core.sv =====
// Instruction sequencer: at most one memory access per cycle, architectural registers
module c65_core
    import c65_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cmd_t        req,
    input  logic [15:0] start_pc,
    input  logic        use_vec,
    output logic        idle,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res,
    output mem_req_t    mem,
    input  logic [7:0]  mem_rdata
);

    state_t      state_reg, state_next;
    logic [7:0]  op_reg, op_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  ptr_reg, ptr_next;
    logic [15:0] ea_reg, ea_next;
    logic [15:0] pc_reg, pc_next;
    logic [7:0]  a_reg, a_next;
    logic [7:0]  x_reg, x_next;
    logic [7:0]  y_reg, y_next;
    logic [7:0]  sp_reg, sp_next;
    logic [7:0]  p_reg, p_next;
    logic [7:0]  data_reg, data_next;
    logic        unimpl_reg, unimpl_next;

    logic [7:0]  op_cur;
    dec_t        dec;
    logic [7:0]  sp_inc;
    logic [7:0]  sp_dec;
    logic [15:0] pc_inc;
    logic [15:0] pc_ret;
    logic        taken;

    // N and Z from a result
    function automatic logic [7:0] f_nz(logic [7:0] p, logic [7:0] v);
        logic [7:0] r;
        r = p;
        r[FL_N] = v[7];
        r[FL_Z] = (v == 8'h00);
        return r;
    endfunction

    // Binary add with carry; returns {p, a}
    function automatic logic [15:0] f_add(logic [7:0] a, logic [7:0] v, logic [7:0] p);
        logic [8:0] s;
        logic [7:0] r;
        logic [7:0] q;
        s = {1'b0, a} + {1'b0, v} + {8'h00, p[FL_C]};
        r = s[7:0];
        q = p;
        q[FL_C] = s[8];
        q[FL_V] = ~(a[7] ^ v[7]) & (a[7] ^ r[7]);
        return {f_nz(q, r), r};
    endfunction

    function automatic logic [7:0] f_cmp(logic [7:0] r, logic [7:0] v, logic [7:0] p);
        logic [7:0] q;
        q = p;
        q[FL_C] = (r >= v);
        return f_nz(q, r - v);
    endfunction

    // kind: 0 ASL, 1 ROL, 2 LSR, 3 ROR; returns {carry, result}
    function automatic logic [8:0] f_shift(logic [1:0] kind, logic [7:0] v, logic cin);
        logic [8:0] r;
        case (kind)
            2'd0:    r = {v[7], v[6:0], 1'b0};
            2'd1:    r = {v[7], v[6:0], cin};
            2'd2:    r = {v[0], 1'b0, v[7:1]};
            default: r = {v[0], cin, v[7:1]};
        endcase
        return r;
    endfunction

    function automatic logic [MEM_AW-1:0] f_maddr(logic [15:0] a);
        return a[MEM_AW-1:0];
    endfunction

    assign op_cur = (state_reg == S_OP) ? mem_rdata : op_reg;
    assign dec    = decode(op_cur);
    assign sp_inc = sp_reg + 8'd1;
    assign sp_dec = sp_reg - 8'd1;
    assign pc_inc = pc_reg + 16'd1;
    assign pc_ret = pc_reg - 16'd1;

    // Branch condition: flag picked by the top two opcode bits, wanted value by bit 5
    always_comb
    begin
        case (op_reg[7:6])
            2'd0:    taken = (p_reg[FL_N] == op_reg[5]);
            2'd1:    taken = (p_reg[FL_V] == op_reg[5]);
            2'd2:    taken = (p_reg[FL_C] == op_reg[5]);
            default: taken = (p_reg[FL_Z] == op_reg[5]);
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start) begin
                    case (req.cmd)
                        CMD_WRITE:   state_next = S_DONE;
                        CMD_READ:    state_next = S_MEMRD;
                        CMD_RESTART: state_next = use_vec ? S_VEC1 : S_DONE;
                        default:     state_next = S_OP;
                    endcase
                end
            end
            S_MEMRD: state_next = S_DONE;
            S_VEC1:  state_next = S_VEC2;
            S_VEC2:  state_next = S_DONE;
            S_OP:
            begin
                case (dec.kind)
                    K_UNIMPL, K_IMPLIED, K_PUSH: state_next = S_DONE;
                    K_PULL:                      state_next = S_PULL1;
                    default:                     state_next = (dec.mode == M_IMM) ? S_EXEC : S_B1;
                endcase
            end
            S_B1:
            begin
                case (dec.mode)
                    M_REL:                  state_next = S_DONE;
                    M_ZPG, M_ZPX, M_ZPY:    state_next = S_EXEC;
                    M_INX, M_INY:           state_next = S_P1;
                    default:                state_next = S_B2;
                endcase
            end
            S_B2:
            begin
                case (dec.kind)
                    K_JMP:   state_next = S_DONE;
                    K_JSR:   state_next = S_JSR2;
                    K_JMPI:  state_next = S_P1;
                    default: state_next = S_EXEC;
                endcase
            end
            S_P1: state_next = S_P2;
            S_P2: state_next = (dec.kind == K_JMPI) ? S_DONE : S_EXEC;
            S_EXEC:
            begin
                if (dec.kind == K_READ || dec.kind == K_RMW) begin
                    state_next = S_DATA;
                end
                else begin
                    state_next = S_DONE;
                end
            end
            S_DATA: state_next = S_DONE;
            S_PULL1:
            begin
                if (op_reg == OPC_RTI) begin
                    state_next = S_PULL2;
                end
                else if (op_reg == OPC_RTS) begin
                    state_next = S_PULL3;
                end
                else begin
                    state_next = S_DONE;
                end
            end
            S_PULL2: state_next = S_PULL3;
            S_PULL3: state_next = S_DONE;
            S_JSR2:  state_next = S_DONE;
            S_DONE:
            begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory requests
    always_comb
    begin
        logic [15:0] t16;
        logic [7:0]  v;
        logic [7:0]  nv;
        logic [8:0]  sh;
        logic [15:0] sum;
        logic [7:0]  pt;
        op_next     = op_reg;
        lo_next     = lo_reg;
        ptr_next    = ptr_reg;
        ea_next     = ea_reg;
        pc_next     = pc_reg;
        a_next      = a_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        sp_next     = sp_reg;
        p_next      = p_reg;
        data_next   = data_reg;
        unimpl_next = unimpl_reg;
        mem         = '0;
        t16         = 16'h0000;
        v           = mem_rdata;
        nv          = 8'h00;
        sh          = 9'h000;
        sum         = 16'h0000;
        pt          = 8'h00;
        case (state_reg)
            S_IDLE:
            begin
                if (start) begin
                    data_next   = 8'h00;
                    unimpl_next = 1'b0;
                    case (req.cmd)
                        CMD_WRITE:
                        begin
                            mem.en    = 1'b1;
                            mem.we    = 1'b1;
                            mem.addr  = f_maddr(req.addr);
                            mem.wdata = req.wdata;
                        end
                        CMD_READ:
                        begin
                            mem.en   = 1'b1;
                            mem.addr = f_maddr(req.addr);
                        end
                        CMD_RESTART:
                        begin
                            a_next  = 8'h00;
                            x_next  = 8'h00;
                            y_next  = 8'h00;
                            sp_next = SP_RST;
                            p_next  = P_RST;
                            pc_next = start_pc;
                            if (use_vec) begin
                                mem.en   = 1'b1;
                                mem.addr = f_maddr(VEC_RESET_LO);
                            end
                        end
                        default:
                        begin
                            mem.en   = 1'b1;
                            mem.addr = f_maddr(pc_reg);
                            pc_next  = pc_inc;
                        end
                    endcase
                end
            end
            S_MEMRD: data_next = mem_rdata;
            S_VEC1:
            begin
                lo_next  = mem_rdata;
                mem.en   = 1'b1;
                mem.addr = f_maddr(VEC_RESET_HI);
            end
            S_VEC2: pc_next = {mem_rdata, lo_reg};
            S_OP:
            begin
                op_next = mem_rdata;
                case (dec.kind)
                    K_UNIMPL: unimpl_next = 1'b1;
                    K_IMPLIED:
                    begin
                        case (mem_rdata)
                            OPC_DEY: begin y_next = y_reg - 8'd1; p_next = f_nz(p_reg, y_next); end
                            OPC_TAY: begin y_next = a_reg; p_next = f_nz(p_reg, a_reg); end
                            OPC_INY: begin y_next = y_reg + 8'd1; p_next = f_nz(p_reg, y_next); end
                            OPC_INX: begin x_next = x_reg + 8'd1; p_next = f_nz(p_reg, x_next); end
                            OPC_DEX: begin x_next = x_reg - 8'd1; p_next = f_nz(p_reg, x_next); end
                            OPC_TYA: begin a_next = y_reg; p_next = f_nz(p_reg, y_reg); end
                            OPC_TXA: begin a_next = x_reg; p_next = f_nz(p_reg, x_reg); end
                            OPC_TAX: begin x_next = a_reg; p_next = f_nz(p_reg, a_reg); end
                            OPC_TSX: begin x_next = sp_reg; p_next = f_nz(p_reg, sp_reg); end
                            OPC_TXS: sp_next = x_reg;
                            OPC_CLC: p_next[FL_C] = 1'b0;
                            OPC_SEC: p_next[FL_C] = 1'b1;
                            OPC_SEI: p_next[FL_I] = 1'b1;
                            OPC_CLV: p_next[FL_V] = 1'b0;
                            OPC_CLD: p_next[FL_D] = 1'b0;
                            OPC_SED: p_next[FL_D] = 1'b1;
                            OPC_ASL, OPC_ROL, OPC_LSR, OPC_ROR:
                            begin
                                sh = f_shift(mem_rdata[6:5], a_reg, p_reg[FL_C]);
                                a_next = sh[7:0];
                                p_next = f_nz(p_reg, sh[7:0]);
                                p_next[FL_C] = sh[8];
                            end
                            default: p_next = p_reg;
                        endcase
                    end
                    K_PUSH:
                    begin
                        mem.en    = 1'b1;
                        mem.we    = 1'b1;
                        mem.addr  = f_maddr(STACK_BASE_W + {8'h00, sp_reg});
                        mem.wdata = (mem_rdata == OPC_PHP) ? (p_reg | 8'h30) : a_reg;
                        sp_next   = sp_dec;
                    end
                    K_PULL:
                    begin
                        sp_next  = sp_inc;
                        mem.en   = 1'b1;
                        mem.addr = f_maddr(STACK_BASE_W + {8'h00, sp_inc});
                    end
                    default:
                    begin
                        if (dec.mode == M_IMM) begin
                            ea_next = pc_reg;
                        end
                        else begin
                            mem.en   = 1'b1;
                            mem.addr = f_maddr(pc_reg);
                        end
                        pc_next = pc_inc;
                    end
                endcase
            end
            S_B1:
            begin
                case (dec.mode)
                    M_REL:
                    begin
                        if (taken) begin
                            pc_next = pc_reg + {{8{mem_rdata[7]}}, mem_rdata};
                        end
                    end
                    M_ZPG: ea_next = {8'h00, mem_rdata};
                    M_ZPX: ea_next = {8'h00, mem_rdata + x_reg};
                    M_ZPY: ea_next = {8'h00, mem_rdata + y_reg};
                    M_INX, M_INY:
                    begin
                        pt       = (dec.mode == M_INX) ? (mem_rdata + x_reg) : mem_rdata;
                        ptr_next = pt;
                        mem.en   = 1'b1;
                        mem.addr = f_maddr({8'h00, pt});
                    end
                    default:
                    begin
                        lo_next  = mem_rdata;
                        mem.en   = 1'b1;
                        mem.addr = f_maddr(pc_reg);
                        pc_next  = pc_inc;
                    end
                endcase
            end
            S_B2:
            begin
                t16 = {mem_rdata, lo_reg};
                if (dec.mode == M_ABX) begin
                    t16 = t16 + {8'h00, x_reg};
                end
                else if (dec.mode == M_ABY) begin
                    t16 = t16 + {8'h00, y_reg};
                end
                ea_next = t16;
                case (dec.kind)
                    K_JMP: pc_next = t16;
                    K_JSR:
                    begin
                        mem.en    = 1'b1;
                        mem.we    = 1'b1;
                        mem.addr  = f_maddr(STACK_BASE_W + {8'h00, sp_reg});
                        mem.wdata = pc_ret[15:8];
                        sp_next   = sp_dec;
                    end
                    K_JMPI:
                    begin
                        mem.en   = 1'b1;
                        mem.addr = f_maddr(t16);
                    end
                    default: ea_next = t16;
                endcase
            end
            S_P1:
            begin
                lo_next = mem_rdata;
                mem.en  = 1'b1;
                if (dec.kind == K_JMPI) begin
                    // page wrap on the pointer's high byte
                    mem.addr = f_maddr({ea_reg[15:8], ea_reg[7:0] + 8'd1});
                end
                else begin
                    mem.addr = f_maddr({8'h00, ptr_reg + 8'd1});
                end
            end
            S_P2:
            begin
                t16 = {mem_rdata, lo_reg};
                if (dec.kind == K_JMPI) begin
                    pc_next = t16;
                end
                else if (dec.mode == M_INY) begin
                    ea_next = t16 + {8'h00, y_reg};
                end
                else begin
                    ea_next = t16;
                end
            end
            S_EXEC:
            begin
                if (dec.kind == K_STORE) begin
                    mem.en   = 1'b1;
                    mem.we   = 1'b1;
                    mem.addr = f_maddr(ea_reg);
                    case (dec.alu)
                        A_STA:   mem.wdata = a_reg;
                        A_STX:   mem.wdata = x_reg;
                        A_STY:   mem.wdata = y_reg;
                        default: mem.wdata = a_reg & x_reg;
                    endcase
                end
                else if (dec.kind == K_READ || dec.kind == K_RMW) begin
                    mem.en   = 1'b1;
                    mem.addr = f_maddr(ea_reg);
                end
            end
            S_DATA:
            begin
                case (dec.alu)
                    A_ORA: begin a_next = a_reg | v; p_next = f_nz(p_reg, a_next); end
                    A_AND: begin a_next = a_reg & v; p_next = f_nz(p_reg, a_next); end
                    A_EOR: begin a_next = a_reg ^ v; p_next = f_nz(p_reg, a_next); end
                    A_ADC:
                    begin
                        sum = f_add(a_reg, v, p_reg);
                        a_next = sum[7:0];
                        p_next = sum[15:8];
                    end
                    A_SBC:
                    begin
                        sum = f_add(a_reg, ~v, p_reg);
                        a_next = sum[7:0];
                        p_next = sum[15:8];
                    end
                    A_LDA: begin a_next = v; p_next = f_nz(p_reg, v); end
                    A_LDX: begin x_next = v; p_next = f_nz(p_reg, v); end
                    A_LDY: begin y_next = v; p_next = f_nz(p_reg, v); end
                    A_LAX: begin a_next = v; x_next = v; p_next = f_nz(p_reg, v); end
                    A_CMP: p_next = f_cmp(a_reg, v, p_reg);
                    A_CPX: p_next = f_cmp(x_reg, v, p_reg);
                    A_CPY: p_next = f_cmp(y_reg, v, p_reg);
                    A_BIT:
                    begin
                        p_next[FL_V] = v[6];
                        p_next[FL_N] = v[7];
                        p_next[FL_Z] = ((a_reg & v) == 8'h00);
                    end
                    A_DEC: begin nv = v - 8'd1; p_next = f_nz(p_reg, nv); end
                    A_INC: begin nv = v + 8'd1; p_next = f_nz(p_reg, nv); end
                    A_DCP: begin nv = v - 8'd1; p_next = f_cmp(a_reg, nv, p_reg); end
                    A_ISB:
                    begin
                        nv = v + 8'd1;
                        sum = f_add(a_reg, ~nv, p_reg);
                        a_next = sum[7:0];
                        p_next = sum[15:8];
                    end
                    A_ASL, A_ROL, A_LSR, A_ROR, A_SLO, A_RLA, A_SRE, A_RRA:
                    begin
                        sh = f_shift(op_reg[6:5], v, p_reg[FL_C]);
                        nv = sh[7:0];
                        pt = p_reg;
                        pt[FL_C] = sh[8];
                        case (dec.alu)
                            A_SLO: begin a_next = a_reg | nv; p_next = f_nz(pt, a_next); end
                            A_RLA: begin a_next = a_reg & nv; p_next = f_nz(pt, a_next); end
                            A_SRE: begin a_next = a_reg ^ nv; p_next = f_nz(pt, a_next); end
                            A_RRA:
                            begin
                                sum = f_add(a_reg, nv, pt);
                                a_next = sum[7:0];
                                p_next = sum[15:8];
                            end
                            default: p_next = f_nz(pt, nv);
                        endcase
                    end
                    default: p_next = p_reg;
                endcase
                if (dec.kind == K_RMW) begin
                    mem.en    = 1'b1;
                    mem.we    = 1'b1;
                    mem.addr  = f_maddr(ea_reg);
                    mem.wdata = nv;
                end
            end
            S_PULL1:
            begin
                if (op_reg == OPC_PLA) begin
                    a_next = mem_rdata;
                    p_next = f_nz(p_reg, mem_rdata);
                end
                else if (op_reg == OPC_RTS) begin
                    lo_next  = mem_rdata;
                    sp_next  = sp_inc;
                    mem.en   = 1'b1;
                    mem.addr = f_maddr(STACK_BASE_W + {8'h00, sp_inc});
                end
                else begin
                    // status pull: B cleared, bit 5 set
                    p_next = (mem_rdata | 8'h20) & 8'hEF;
                    if (op_reg == OPC_RTI) begin
                        sp_next  = sp_inc;
                        mem.en   = 1'b1;
                        mem.addr = f_maddr(STACK_BASE_W + {8'h00, sp_inc});
                    end
                end
            end
            S_PULL2:
            begin
                lo_next  = mem_rdata;
                sp_next  = sp_inc;
                mem.en   = 1'b1;
                mem.addr = f_maddr(STACK_BASE_W + {8'h00, sp_inc});
            end
            S_PULL3:
            begin
                pc_next = {mem_rdata, lo_reg} + {15'h0000, (op_reg == OPC_RTS)};
            end
            S_JSR2:
            begin
                mem.en    = 1'b1;
                mem.we    = 1'b1;
                mem.addr  = f_maddr(STACK_BASE_W + {8'h00, sp_reg});
                mem.wdata = pc_ret[7:0];
                sp_next   = sp_dec;
                pc_next   = ea_reg;
            end
            default: pc_next = pc_reg;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    // Architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg     <= START_PC_RST;
            a_reg      <= 8'h00;
            x_reg      <= 8'h00;
            y_reg      <= 8'h00;
            sp_reg     <= SP_RST;
            p_reg      <= P_RST;
            data_reg   <= 8'h00;
            unimpl_reg <= 1'b0;
        end
        else begin
            pc_reg     <= pc_next;
            a_reg      <= a_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            sp_reg     <= sp_next;
            p_reg      <= p_next;
            data_reg   <= data_next;
            unimpl_reg <= unimpl_next;
        end
    end

    // Per-instruction scratch
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        lo_reg  <= lo_next;
        ptr_reg <= ptr_next;
        ea_reg  <= ea_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = '{pc: pc_reg, a: a_reg, x: x_reg, y: y_reg, sp: sp_reg, p: p_reg,
                         mem_data: data_reg, unimpl: unimpl_reg};

endmodule
